// ===== sv/mll_pkg.sv =====
// Shared constants, types and control structs of the micro language lexer.
package mll_pkg;

    localparam int MAX_WORD_LEN   = 16;
    localparam int MAX_STRING_LEN = 32;

    localparam int TLW = $clog2(MAX_WORD_LEN + 1);
    localparam int SLW = $clog2(MAX_STRING_LEN + 1);
    localparam int RLW = (TLW > SLW) ? TLW : SLW;
    localparam int WAW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int SAW = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;

    localparam int NSLOT = 4;

    typedef enum logic [3:0] {
        TOK_EOF    = 4'd0,
        TOK_ID     = 4'd1,
        TOK_INT    = 4'd2,
        TOK_LPAREN = 4'd3,
        TOK_RPAREN = 4'd4,
        TOK_SEMI   = 4'd5,
        TOK_COMMA  = 4'd6,
        TOK_PLUS   = 4'd7,
        TOK_MINUS  = 4'd8,
        TOK_ASSIGN = 4'd9,
        TOK_LISTEN = 4'd10,
        TOK_SHOUT  = 4'd11,
        TOK_STRING = 4'd12
    } token_code_t;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_INT     = 4'd2,
        M_COLON   = 4'd3,
        M_DASH    = 4'd4,
        M_COMMENT = 4'd5,
        M_STR     = 4'd6,
        M_STRQ    = 4'd7
    } scan_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic emit_run;
        logic emit_fix;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic has_out;
        logic run_en;
        logic slot_free;
        logic run_last;
        logic fix_last;
    } dp_status_t;

    typedef struct packed {
        logic        is_code;
        token_code_t code;
        logic [7:0]  ch;
    } result_t;

endpackage

// ===== sv/mll_char_if.sv =====
// Source byte channel: valid/ready transfer of one byte or end-of-input mark.
interface mll_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink (input valid, input kind, input char_code, output ready);
endinterface

// ===== sv/mll_tok_if.sv =====
// Token result channel: valid/ready transfer of one text character or token code.
interface mll_tok_if
    import mll_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        result_type;
    token_code_t token_code;
    logic [7:0]  text_char;
    logic        last_of_run;

    modport source (output valid, output result_type, output token_code,
                    output text_char, output last_of_run, input ready);
    modport sink (input valid, input result_type, input token_code,
                  input text_char, input last_of_run, output ready);
endinterface

// ===== sv/mll_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mll_ctrl.sv =====
// Lexer sequencer: accepts bytes and steps the datapath through result emission.
module mll_ctrl
    import mll_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.has_out)
                begin
                    state_next = status.run_en ? S_RUN : S_FIX;
                end
            end
            S_RUN:
            begin
                if (status.slot_free && status.run_last)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (status.slot_free && status.fix_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.emit_run = 1'b0;
        cmd.emit_fix = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_RUN:
            begin
                cmd.emit_run = 1'b1;
            end
            S_FIX:
            begin
                cmd.emit_fix = 1'b1;
                cmd.commit   = status.slot_free && status.fix_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/mll_dp.sv =====
// Lexer datapath: scan state, text buffers, result plan and output register.
module mll_dp
    import mll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        kind,
    input  logic [7:0]  char_code,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        result_type,
    output token_code_t token_code,
    output logic [7:0]  text_char,
    output logic        last_of_run
);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= "a") && (c <= "z");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || is_lower(c);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] listen_char(input int i);
        logic [7:0] r;
        case (i)
            0:       r = "L";
            1:       r = "I";
            2:       r = "S";
            3:       r = "T";
            4:       r = "E";
            5:       r = "N";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] shout_char(input int i);
        logic [7:0] r;
        case (i)
            0:       r = "S";
            1:       r = "H";
            2:       r = "O";
            3:       r = "U";
            4:       r = "T";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // scan state
    scan_mode_t     mode_reg, mode_next;
    logic [TLW-1:0] tl_reg, tl_next;
    logic [SLW-1:0] sl_reg, sl_next;
    logic           lis_reg, lis_next;
    logic           sho_reg, sho_next;

    // deferred word write
    logic           pend_reg, pend_next;
    logic [WAW-1:0] pend_addr_reg;
    logic [7:0]     pend_data_reg;

    // result plan
    logic             run_src_reg;
    logic [RLW-1:0]   run_len_reg;
    logic [RLW-1:0]   idx_reg, idx_next;
    result_t          slot_reg [NSLOT];
    result_t          slot_next [NSLOT];
    logic [NSLOT-1:0] vld_reg, vld_next, vld_new, vld_rest;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    out_last_reg;

    // scan decode
    logic [7:0]     cu;
    logic           do_start, new_word, wadd, sadd;
    logic           flush_w, flush_s, dash, fw_int;
    logic           tail_code_en, tail_plus;
    token_code_t    tail_code, word_code;
    logic [TLW-1:0] word_base;
    logic           word_wr, str_wr, run_en;
    logic [RLW-1:0] run_len_new;

    logic       slot_free, load, fix_last;
    result_t    fix_sel;
    logic [7:0] w_rdata, s_rdata;
    logic       w_we;
    logic [WAW-1:0] w_waddr;
    logic [7:0] w_wdata;

    assign cu = is_lower(char_code) ? (char_code - CASE_GAP) : char_code;

    always_comb
    begin
        mode_next    = mode_reg;
        sl_next      = sl_reg;
        do_start     = 1'b0;
        new_word     = 1'b0;
        wadd         = 1'b0;
        sadd         = 1'b0;
        flush_w      = 1'b0;
        flush_s      = 1'b0;
        dash         = 1'b0;
        fw_int       = 1'b0;
        tail_code_en = 1'b0;
        tail_plus    = 1'b0;
        tail_code    = TOK_EOF;
        if (kind)
        begin
            case (mode_reg)
                M_IDENT: flush_w = 1'b1;
                M_INT:
                begin
                    flush_w = 1'b1;
                    fw_int  = 1'b1;
                end
                M_DASH:  dash = 1'b1;
                M_STRQ:  flush_s = 1'b1;
                default: dash = 1'b0;
            endcase
            sl_next      = '0;
            mode_next    = M_IDLE;
            tail_code_en = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(char_code) || is_digit(char_code) || char_code == CH_UNDER)
                    begin
                        wadd = 1'b1;
                    end
                    else
                    begin
                        flush_w  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(char_code))
                    begin
                        wadd = 1'b1;
                    end
                    else
                    begin
                        flush_w  = 1'b1;
                        fw_int   = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_COLON:
                begin
                    if (char_code == CH_EQ)
                    begin
                        tail_code_en = 1'b1;
                        tail_code    = TOK_ASSIGN;
                        mode_next    = M_IDLE;
                    end
                    else
                    begin
                        do_start = 1'b1;
                    end
                end
                M_DASH:
                begin
                    if (char_code == CH_MINUS)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        dash     = 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (char_code == CH_LF)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_STR:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        mode_next = M_STRQ;
                    end
                    else if (char_code == CH_LF)
                    begin
                        sl_next   = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        sadd = 1'b1;
                    end
                end
                M_STRQ:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        sadd      = 1'b1;
                        mode_next = M_STR;
                    end
                    else
                    begin
                        flush_s  = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
            if (flush_s)
            begin
                sl_next = '0;
            end
            if (do_start)
            begin
                mode_next = M_IDLE;
                if (is_alpha(char_code))
                begin
                    new_word  = 1'b1;
                    wadd      = 1'b1;
                    mode_next = M_IDENT;
                end
                else if (is_digit(char_code))
                begin
                    new_word  = 1'b1;
                    wadd      = 1'b1;
                    mode_next = M_INT;
                end
                else
                begin
                    case (char_code)
                        CH_LPAREN:
                        begin
                            tail_code_en = 1'b1;
                            tail_code    = TOK_LPAREN;
                        end
                        CH_RPAREN:
                        begin
                            tail_code_en = 1'b1;
                            tail_code    = TOK_RPAREN;
                        end
                        CH_SEMI:
                        begin
                            tail_code_en = 1'b1;
                            tail_code    = TOK_SEMI;
                        end
                        CH_COMMA:
                        begin
                            tail_code_en = 1'b1;
                            tail_code    = TOK_COMMA;
                        end
                        CH_PLUS:
                        begin
                            tail_plus    = 1'b1;
                            tail_code_en = 1'b1;
                            tail_code    = TOK_PLUS;
                        end
                        CH_COLON: mode_next = M_COLON;
                        CH_MINUS: mode_next = M_DASH;
                        CH_QUOTE:
                        begin
                            sl_next   = '0;
                            mode_next = M_STR;
                        end
                        default: mode_next = M_IDLE;
                    endcase
                end
            end
        end
        // string append saturates at the buffer length
        str_wr = sadd && (sl_reg < SLW'(MAX_STRING_LEN));
        if (str_wr)
        begin
            sl_next = sl_reg + SLW'(1);
        end
    end

    // word append, reserved-word prefix tracking
    always_comb
    begin
        word_base = new_word ? '0 : tl_reg;
        word_wr   = wadd && (word_base < TLW'(MAX_WORD_LEN));
        tl_next   = (flush_w || kind) ? '0 : tl_reg;
        lis_next  = lis_reg;
        sho_next  = sho_reg;
        if (word_wr)
        begin
            tl_next  = word_base + TLW'(1);
            lis_next = (new_word || lis_reg) && (int'(word_base) < 6)
                       && (cu == listen_char(int'(word_base)));
            sho_next = (new_word || sho_reg) && (int'(word_base) < 5)
                       && (cu == shout_char(int'(word_base)));
        end
    end

    always_comb
    begin
        if (fw_int)
        begin
            word_code = TOK_INT;
        end
        else if (lis_reg && int'(tl_reg) == 6)
        begin
            word_code = TOK_LISTEN;
        end
        else if (sho_reg && int'(tl_reg) == 5)
        begin
            word_code = TOK_SHOUT;
        end
        else
        begin
            word_code = TOK_ID;
        end
    end

    // result plan: buffered run, then up to four fixed results
    always_comb
    begin
        run_en      = (flush_w && tl_reg != '0) || (flush_s && sl_reg != '0);
        run_len_new = flush_s ? RLW'(sl_reg) : RLW'(tl_reg);
        slot_next[0] = '{is_code: 1'b0, code: TOK_EOF, ch: CH_MINUS};
        slot_next[1] = '{is_code: 1'b1,
                         code: dash ? TOK_MINUS : (flush_s ? TOK_STRING : word_code),
                         ch: 8'h00};
        slot_next[2] = '{is_code: 1'b0, code: TOK_EOF, ch: CH_PLUS};
        slot_next[3] = '{is_code: 1'b1, code: tail_code, ch: 8'h00};
        vld_new = {tail_code_en, tail_plus, dash || flush_w || flush_s, dash};
    end

    // fixed-result selection
    always_comb
    begin
        fix_sel = slot_reg[0];
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (vld_reg[i])
            begin
                fix_sel = slot_reg[i];
            end
        end
        vld_rest = vld_reg & (vld_reg - NSLOT'(1));
        fix_last = (vld_rest == '0);
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign load      = (cmd.emit_run || cmd.emit_fix) && slot_free;

    always_comb
    begin
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_run && slot_free)
        begin
            idx_next = idx_reg + RLW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end

        if (cmd.accept)
        begin
            vld_next = vld_new;
        end
        else if (cmd.emit_fix && slot_free)
        begin
            vld_next = vld_rest;
        end
        else
        begin
            vld_next = vld_reg;
        end

        if (cmd.accept)
        begin
            pend_next = word_wr && run_en;
        end
        else if (cmd.commit)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            tl_reg        <= '0;
            sl_reg        <= '0;
            lis_reg       <= 1'b0;
            sho_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                mode_reg <= mode_next;
                tl_reg   <= tl_next;
                sl_reg   <= sl_next;
                lis_reg  <= lis_next;
                sho_reg  <= sho_next;
            end
            pend_reg      <= pend_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.accept)
        begin
            run_src_reg   <= flush_s;
            run_len_reg   <= run_len_new;
            pend_addr_reg <= word_base[WAW-1:0];
            pend_data_reg <= cu;
            for (int i = 0; i < NSLOT; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
        if (load)
        begin
            if (cmd.emit_run)
            begin
                out_res_reg  <= '{is_code: 1'b0, code: TOK_EOF,
                                  ch: run_src_reg ? s_rdata : w_rdata};
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_res_reg  <= fix_sel;
                out_last_reg <= fix_last;
            end
        end
    end

    // word writes that collide with a pending flush wait until the run is out
    assign w_we    = (cmd.accept && word_wr && !run_en) || (cmd.commit && pend_reg);
    assign w_waddr = cmd.commit ? pend_addr_reg : word_base[WAW-1:0];
    assign w_wdata = cmd.commit ? pend_data_reg : cu;

    mll_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD_LEN)
    ) u_word_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (idx_next[WAW-1:0]),
        .rdata (w_rdata)
    );

    mll_ram #(
        .WIDTH (8),
        .DEPTH (MAX_STRING_LEN)
    ) u_str_ram (
        .clk   (clk),
        .we    (cmd.accept && str_wr),
        .waddr (sl_reg[SAW-1:0]),
        .wdata (char_code),
        .raddr (idx_next[SAW-1:0]),
        .rdata (s_rdata)
    );

    assign status.has_out   = (vld_new != '0);
    assign status.run_en    = run_en;
    assign status.slot_free = slot_free;
    assign status.run_last  = ((idx_reg + RLW'(1)) == run_len_reg);
    assign status.fix_last  = fix_last;

    assign out_valid   = out_valid_reg;
    assign result_type = out_res_reg.is_code;
    assign token_code  = out_res_reg.code;
    assign text_char   = out_res_reg.ch;
    assign last_of_run = out_last_reg;

endmodule

// ===== sv/micro_language_lexer_unit.sv =====
// Micro language lexer top level: byte stream in, token results out.
// One source byte (or end-of-input mark) is taken per transfer on chars; each
// byte that completes a token produces a run of results on tokens: the buffered
// token text one character per transfer, then the token code, the final result
// of the byte marked last_of_run. A byte that produces no result leaves the
// lexer ready for the next byte. A byte that produces results is accepted and
// planned, then its results go out one at a time, each paced by the single
// output register and the sequencer that loads it; the next byte is accepted in
// the cycle after the last result is loaded. Identifier text is kept up to 16
// characters and string text up to 32, in two small RAMs with registered read.
module micro_language_lexer_unit
    import mll_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    mll_char_if.sink    chars,
    mll_tok_if.source   tokens
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mll_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (chars.kind),
        .char_code   (chars.char_code),
        .out_ready   (tokens.ready),
        .out_valid   (tokens.valid),
        .result_type (tokens.result_type),
        .token_code  (tokens.token_code),
        .text_char   (tokens.text_char),
        .last_of_run (tokens.last_of_run)
    );

    // end of input always yields at least an eof result
    a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && chars.kind |=> !chars.ready)
        else $error("end-of-input transfer left the lexer idle");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && !tokens.result_type |-> tokens.token_code == TOK_EOF)
        else $error("text character carries a token code");

    a_code_text: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.result_type |-> tokens.text_char == 8'h00)
        else $error("token code carries text");

    a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.last_of_run |-> tokens.result_type)
        else $error("run ended on a text character");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the micro language lexer: random byte streams vs. a token predictor.
module tb;
    import mll_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
    } src_item_t;

    typedef struct packed {
        logic        result_type;
        token_code_t token_code;
        logic [7:0]  text_char;
        logic        last_of_run;
    } lex_result_t;

    class lexer_scoreboard;
        scan_mode_t    mode;
        logic [7:0]    word_buf[MAX_WORD_LEN];
        int            word_len;
        logic [7:0]    str_buf[MAX_STRING_LEN];
        int            str_len;
        lex_result_t   step_q[$];
        lex_result_t   predicted_tokens[$];
        int            errors;
        int            bytes_taken;
        int            results_taken;
        int            codes_taken;

        function new();
            mode = M_IDLE;
            word_len = 0;
            str_len = 0;
            errors = 0;
            bytes_taken = 0;
            results_taken = 0;
            codes_taken = 0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void emit(logic is_code, token_code_t code, logic [7:0] ch);
            lex_result_t r;
            r.result_type = is_code;
            r.token_code = code;
            r.text_char = ch;
            r.last_of_run = 1'b0;
            step_q.push_back(r);
        endfunction

        function void word_add(logic [7:0] c);
            if (word_len < MAX_WORD_LEN)
            begin
                if (c >= "a" && c <= "z")
                    c = c - 8'd32;
                word_buf[word_len] = c;
                word_len++;
            end
        endfunction

        function void string_add(logic [7:0] c);
            if (str_len < MAX_STRING_LEN)
            begin
                str_buf[str_len] = c;
                str_len++;
            end
        endfunction

        function bit word_matches(string w);
            if (word_len != w.len())
                return 0;
            for (int i = 0; i < word_len; i++)
                if (word_buf[i] != w[i])
                    return 0;
            return 1;
        endfunction

        function void flush_word(token_code_t code);
            for (int i = 0; i < word_len; i++)
                emit(1'b0, TOK_EOF, word_buf[i]);
            if (code == TOK_ID)
            begin
                if (word_matches("LISTEN"))
                    code = TOK_LISTEN;
                else if (word_matches("SHOUT"))
                    code = TOK_SHOUT;
            end
            word_len = 0;
            emit(1'b1, code, 8'h00);
        endfunction

        function void flush_string();
            for (int i = 0; i < str_len; i++)
                emit(1'b0, TOK_EOF, str_buf[i]);
            str_len = 0;
            emit(1'b1, TOK_STRING, 8'h00);
        endfunction

        function void flush_minus();
            emit(1'b0, TOK_EOF, "-");
            emit(1'b1, TOK_MINUS, 8'h00);
        endfunction

        function void begin_token(logic [7:0] c);
            mode = M_IDLE;
            if (is_alpha(c))
            begin
                word_len = 0;
                word_add(c);
                mode = M_IDENT;
            end
            else if (is_digit(c))
            begin
                word_len = 0;
                word_add(c);
                mode = M_INT;
            end
            else if (c == "(")
                emit(1'b1, TOK_LPAREN, 8'h00);
            else if (c == ")")
                emit(1'b1, TOK_RPAREN, 8'h00);
            else if (c == ";")
                emit(1'b1, TOK_SEMI, 8'h00);
            else if (c == ",")
                emit(1'b1, TOK_COMMA, 8'h00);
            else if (c == "+")
            begin
                emit(1'b0, TOK_EOF, "+");
                emit(1'b1, TOK_PLUS, 8'h00);
            end
            else if (c == ":")
                mode = M_COLON;
            else if (c == "-")
                mode = M_DASH;
            else if (c == "\"")
            begin
                str_len = 0;
                mode = M_STR;
            end
        endfunction

        // predicts the results of one accepted source transfer
        function void take_source(logic kind, logic [7:0] c);
            lex_result_t r;
            step_q.delete();
            bytes_taken++;
            if (kind)
            begin
                case (mode)
                    M_IDENT: flush_word(TOK_ID);
                    M_INT:   flush_word(TOK_INT);
                    M_DASH:  flush_minus();
                    M_STRQ:  flush_string();
                    default: ;
                endcase
                str_len = 0;
                word_len = 0;
                mode = M_IDLE;
                emit(1'b1, TOK_EOF, 8'h00);
            end
            else
            begin
                case (mode)
                    M_IDENT:
                        if (is_alpha(c) || is_digit(c) || c == "_")
                            word_add(c);
                        else
                        begin
                            flush_word(TOK_ID);
                            begin_token(c);
                        end
                    M_INT:
                        if (is_digit(c))
                            word_add(c);
                        else
                        begin
                            flush_word(TOK_INT);
                            begin_token(c);
                        end
                    M_COLON:
                        if (c == "=")
                        begin
                            emit(1'b1, TOK_ASSIGN, 8'h00);
                            mode = M_IDLE;
                        end
                        else
                            begin_token(c);
                    M_DASH:
                        if (c == "-")
                            mode = M_COMMENT;
                        else
                        begin
                            flush_minus();
                            begin_token(c);
                        end
                    M_COMMENT:
                        if (c == "\n")
                            mode = M_IDLE;
                    M_STR:
                        if (c == "\"")
                            mode = M_STRQ;
                        else if (c == "\n")
                        begin
                            str_len = 0;
                            mode = M_IDLE;
                        end
                        else
                            string_add(c);
                    M_STRQ:
                        if (c == "\"")
                        begin
                            string_add("\"");
                            mode = M_STR;
                        end
                        else
                        begin
                            flush_string();
                            begin_token(c);
                        end
                    default:
                        begin_token(c);
                endcase
            end
            for (int i = 0; i < step_q.size(); i++)
            begin
                r = step_q[i];
                r.last_of_run = (i == step_q.size() - 1);
                predicted_tokens.push_back(r);
            end
        endfunction

        function void check_token(logic rtype, token_code_t code, logic [7:0] ch, logic last);
            lex_result_t exp_r;
            results_taken++;
            if (predicted_tokens.size() == 0)
            begin
                $error("unexpected result: type %0d code %0d char %0d last %0d",
                       rtype, code, ch, last);
                errors++;
                return;
            end
            exp_r = predicted_tokens.pop_front();
            if (exp_r.result_type)
                codes_taken++;
            if (rtype !== exp_r.result_type)
            begin
                $error("result_type: expected %0d, got %0d", exp_r.result_type, rtype);
                errors++;
            end
            if (code !== exp_r.token_code)
            begin
                $error("token_code: expected %0d, got %0d", exp_r.token_code, code);
                errors++;
            end
            if (ch !== exp_r.text_char)
            begin
                $error("text_char: expected %0d, got %0d", exp_r.text_char, ch);
                errors++;
            end
            if (last !== exp_r.last_of_run)
            begin
                $error("last_of_run: expected %0d, got %0d", exp_r.last_of_run, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mll_char_if chars_if();
    mll_tok_if  tokens_if();

    micro_language_lexer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    lexer_scoreboard sb;
    src_item_t       src_items[$];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void push_byte(logic [7:0] c);
        src_items.push_back('{kind: 1'b0, ch: c});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_eof();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        src_items.push_back('{kind: 1'b1, ch: c});
    endfunction

    function automatic logic [7:0] rand_case(logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
            return c + 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = "A" + 8'($urandom_range(0, 25));
        return rand_case(c);
    endfunction

    function automatic logic [7:0] rand_digit();
        logic [7:0] c;
        c = "0" + 8'($urandom_range(0, 9));
        return c;
    endfunction

    // printable string body byte, quote doubled now and then
    function automatic void push_string_body(int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_byte("\"");
                push_byte("\"");
            end
            else
            begin
                c = 8'($urandom_range(32, 126));
                if (c == "\"")
                    c = "'";
                push_byte(c);
            end
        end
    endfunction

    function automatic int add_fragment();
        int         sel;
        int         len;
        int         r;
        string      w;
        logic [7:0] c;
        sel = $urandom_range(0, 19);
        case (sel)
            0, 1, 2:
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
                push_byte(rand_letter());
                for (int i = 1; i < len; i++)
                begin
                    r = $urandom_range(0, 3);
                    if (r < 2)
                        push_byte(rand_letter());
                    else if (r == 2)
                        push_byte(rand_digit());
                    else
                        push_byte("_");
                end
            end
            3:
            begin
                if ($urandom_range(0, 1))
                    w = "LISTEN";
                else
                    w = "SHOUT";
                for (int i = 0; i < w.len(); i++)
                    push_byte(rand_case(w[i]));
                if ($urandom_range(0, 3) == 0)
                    push_byte(rand_letter());
            end
            4, 5:
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    push_byte(rand_digit());
            end
            6:
            begin
                w = "();,+";
                push_byte(w[$urandom_range(0, 4)]);
            end
            7:
                push_text(":=");
            8:
                push_byte(":");
            9:
                push_byte("-");
            10:
            begin
                push_text("--");
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == "\n")
                        c = "x";
                    push_byte(c);
                end
                if ($urandom_range(0, 4) == 0)
                    push_eof();
                else
                    push_byte("\n");
            end
            11, 12:
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
                push_byte("\"");
                push_string_body(len);
                push_byte("\"");
            end
            13:
            begin
                push_byte("\"");
                push_string_body($urandom_range(0, 5));
                push_byte("\n");
            end
            14:
                push_eof();
            15:
            begin
                push_byte("\"");
                push_string_body($urandom_range(0, 4));
                if ($urandom_range(0, 1))
                    push_byte("\"");
                push_eof();
            end
            16:
            begin
                push_byte("-");
                push_eof();
            end
            17:
            begin
                c = 8'($urandom_range(0, 255));
                push_byte(c);
                return 0;
            end
            default:
            begin
                w = " \t\n\r";
                push_byte(w[$urandom_range(0, 3)]);
                return 0;
            end
        endcase
        return 1;
    endfunction

    task automatic send_item(src_item_t it, int gap);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.kind <= it.kind;
        chars_if.char_code <= it.ch;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tokens_if.valid && tokens_if.ready)
                sb.check_token(tokens_if.result_type, tokens_if.token_code,
                               tokens_if.text_char, tokens_if.last_of_run);
            if (chars_if.valid && chars_if.ready)
                sb.take_source(chars_if.kind, chars_if.char_code);
        end
    end

    // result side: random stalls, bursts, and one long hold-off
    initial
    begin
        int  stall;
        int  taken;
        bit  held;
        bit  burst;
        taken = 0;
        held = 0;
        burst = 0;
        tokens_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (!held && taken >= 40)
            begin
                held = 1;
                stall = 300;
            end
            else
                stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                tokens_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            tokens_if.ready <= 1'b1;
            @(posedge clk);
            while (!tokens_if.valid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int  counted;
        int  gap;
        bit  burst;
        sb = new();
        chars_if.valid = 1'b0;
        chars_if.kind = 1'b0;
        chars_if.char_code = 8'h00;
        rst_n = 1'b0;

        // reserved word, punctuation, assign, stray colon, doubled quote, comment
        push_text("listen(a,9);+-:=:x\"a\"\"b\"--\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        src_items.push_back('{kind: 1'b1, ch: 8'hFF});

        counted = 0;
        while (src_items.size() < 190)
            counted += add_fragment();
        push_eof();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        burst = 0;
        for (int i = 0; i < src_items.size(); i++)
        begin
            if (i % 16 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 5);
            send_item(src_items[i], gap);
        end
        chars_if.valid <= 1'b0;

        while (sb.predicted_tokens.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Run covered %0d source transfers and %0d result transfers (%0d token codes)",
                 sb.bytes_taken, sb.results_taken, sb.codes_taken);
        $display("over identifiers, literals, operators, strings, comments and end marks.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
